FILE: src/hslrgb_pkg.sv
// Shared types, constants and helpers for the HSL to RGB converter.
// No dependencies; every other file but the checker imports this package.
package hslrgb_pkg;

  // Saturation and lightness arrive as 9-bit levels where 256 means 1.0.
  localparam int LVL_W = 9;
  localparam logic [LVL_W-1:0] LVL_ONE = 9'd256;
  localparam logic [LVL_W-1:0] LVL_HALF = 9'd128;

  // Internal fractions carry 16 fraction bits plus one bit for exactly 1.0.
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // Which piece of the hue rule a channel falls into.
  typedef enum logic [1:0] {
    REGION_RISE = 2'd0,
    REGION_HIGH = 2'd1,
    REGION_FALL = 2'd2,
    REGION_LOW  = 2'd3
  } hslrgb_region_t;

  // Low and high ends of the channel span.
  typedef struct packed {
    logic [FRAC_W-1:0] p;
    logic [FRAC_W-1:0] q;
  } hslrgb_pq_t;

  // Load enables for the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } hslrgb_adv_t;

  // Scales a fraction by 255 and truncates: (f * 255) >> 16 as a shift and subtract.
  function automatic logic [7:0] to_byte(input logic [FRAC_W-1:0] f);
    logic [FRAC_W-1:0] c;
    logic [FRAC_W+7:0] x;
    c = (f > FRAC_ONE) ? FRAC_ONE : f;
    x = {c, 8'b0} - {8'b0, c};
    return x[23:16];
  endfunction

endpackage

FILE: src/hslrgb_ctrl.sv
// Valid tracking and stall control for the four-stage converter pipeline.
// Depends on hslrgb_pkg for the stage enable struct.
module hslrgb_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output hslrgb_pkg::hslrgb_adv_t adv
);
  import hslrgb_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // A stage may load when it is empty or its content moves on this cycle,
  // so bubbles collapse and a full pipeline still flows whenever the output is taken.
  assign rdy4 = !v4 || rsp_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  assign req_ready = rdy1;
  assign rsp_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= req_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

endmodule

FILE: src/hslrgb_pq.sv
// Stages one to three of the span path: saturation, lightness times saturation,
// then the p and q ends of the channel span. Depends on hslrgb_pkg.
module hslrgb_pq (
  input  logic                    clk,
  input  hslrgb_pkg::hslrgb_adv_t adv,
  input  logic [8:0]              saturation,
  input  logic [8:0]              lightness,
  output hslrgb_pkg::hslrgb_pq_t  pq2,
  output hslrgb_pkg::hslrgb_pq_t  pq3
);
  import hslrgb_pkg::*;

  logic [LVL_W-1:0]    s_sat, l_sat;
  logic [2*LVL_W-1:0]  ls_full;
  logic [LVL_W-1:0]    s1, l1;
  logic [FRAC_W-1:0]   ls1;
  logic [FRAC_W-1:0]   l16, s16;
  logic [FRAC_W:0]     q_raw, two_l, p_raw;
  logic [FRAC_W-1:0]   q_next, p_next;

  assign s_sat = (saturation > LVL_ONE) ? LVL_ONE : saturation;
  assign l_sat = (lightness > LVL_ONE) ? LVL_ONE : lightness;
  // With both sides widened by 8 bits, (l16 * s16) >> 16 is exactly l * s.
  assign ls_full = {{LVL_W{1'b0}}, l_sat} * {{LVL_W{1'b0}}, s_sat};

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1  <= s_sat;
      l1  <= l_sat;
      ls1 <= ls_full[FRAC_W-1:0];
    end
  end

  assign l16 = {l1, 8'b0};
  assign s16 = {s1, 8'b0};

  // Zero saturation needs no special path: it gives p = q = lightness.
  always_comb begin
    if (l1 < LVL_HALF) begin
      q_raw = {1'b0, l16} + {1'b0, ls1};
    end else begin
      q_raw = {1'b0, l16} + {1'b0, s16} - {1'b0, ls1};
    end
    q_next = (q_raw > {1'b0, FRAC_ONE}) ? FRAC_ONE : q_raw[FRAC_W-1:0];
    two_l  = {l16, 1'b0};
    p_raw  = (two_l > {1'b0, q_next}) ? (two_l - {1'b0, q_next}) : '0;
    p_next = (p_raw > {1'b0, q_next}) ? q_next : p_raw[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pq2.p <= p_next;
      pq2.q <= q_next;
    end
    if (adv.s3) begin
      pq3 <= pq2;
    end
  end

endmodule

FILE: src/hslrgb_chan.sv
// One color channel: hue offset, region decode, span multiply and byte scaling
// over four stages. Depends on hslrgb_pkg and on p and q from hslrgb_pq.
module hslrgb_chan #(
  parameter int HUE_BITS = 16,
  parameter logic [HUE_BITS-1:0] HUE_OFFSET = '0
) (
  input  logic                    clk,
  input  hslrgb_pkg::hslrgb_adv_t adv,
  input  logic [HUE_BITS-1:0]     hue,
  input  hslrgb_pkg::hslrgb_pq_t  pq2,
  input  hslrgb_pkg::hslrgb_pq_t  pq3,
  output logic [7:0]              level
);
  import hslrgb_pkg::*;

  localparam int MUL_W  = HUE_BITS + 1;
  localparam int PROD_W = FRAC_W + MUL_W;

  localparam logic [HUE_BITS+2:0] TURN_X6 = {3'b001, {HUE_BITS{1'b0}}};
  localparam logic [HUE_BITS+1:0] TWO_TURN = {2'b10, {HUE_BITS{1'b0}}};

  logic [HUE_BITS-1:0]  t1;
  logic [HUE_BITS+2:0]  six_t;
  logic [HUE_BITS+1:0]  three_t, fall_d;
  logic [MUL_W-1:0]     mul_next, mul2;
  hslrgb_region_t       region_next, region2, region3;
  logic [FRAC_W-1:0]    span;
  logic [PROD_W-1:0]    prod;
  logic [FRAC_W-1:0]    frac3;
  logic [FRAC_W-1:0]    chan_val;

  // Stage 1: channel hue, wrapping modulo one turn.
  always_ff @(posedge clk) begin
    if (adv.s1) t1 <= hue + HUE_OFFSET;
  end

  // Stage 2: exact region tests on 6t, 2t and 3t, and the ramp multiplier.
  assign six_t   = {1'b0, t1, 2'b00} + {2'b00, t1, 1'b0};
  assign three_t = {1'b0, t1, 1'b0} + {2'b00, t1};
  assign fall_d  = TWO_TURN - three_t;

  always_comb begin
    priority if (six_t < TURN_X6) begin
      region_next = REGION_RISE;
      mul_next    = six_t[MUL_W-1:0];
    end else if (!t1[HUE_BITS-1]) begin
      region_next = REGION_HIGH;
      mul_next    = '0;
    end else if (three_t < TWO_TURN) begin
      // On the falling edge 2T - 3t is at most half a turn.
      region_next = REGION_FALL;
      mul_next    = {fall_d[HUE_BITS-1:0], 1'b0};
    end else begin
      region_next = REGION_LOW;
      mul_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      region2 <= region_next;
      mul2    <= mul_next;
    end
  end

  // Stage 3: span times ramp position, back to a 16-bit fraction.
  assign span = pq2.q - pq2.p;
  assign prod = PROD_W'(span) * PROD_W'(mul2);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      region3 <= region2;
      frac3   <= prod[HUE_BITS +: FRAC_W];
    end
  end

  // Stage 4: pick the channel fraction and scale it to a byte.
  always_comb begin
    unique case (region3)
      REGION_RISE: chan_val = pq3.p + frac3;
      REGION_FALL: chan_val = pq3.p + frac3;
      REGION_HIGH: chan_val = pq3.q;
      REGION_LOW:  chan_val = pq3.p;
      default:     chan_val = pq3.p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s4) level <= to_byte(chan_val);
  end

endmodule

FILE: src/hsl_to_rgb_converter_top.sv
// Top level of the HSL to RGB converter: control, span path and three channels.
// Depends on hslrgb_pkg, hslrgb_ctrl, hslrgb_pq and hslrgb_chan.
//
// Usage:
//   A request carries hue (HUE_BITS-bit fraction of a turn, wrapping),
//   saturation and lightness (9 bits, 256 means 1.0, larger values clamp).
//   The response carries 8-bit red, green and blue.
//   Both channels use valid and ready; a transfer happens when both are high.
//   The block is a four-stage pipeline: a request accepted into stage one
//   passes through stages two and three, and its response is registered in
//   stage four, where the receiver can take it when nothing stalls.
//   It takes one request per clock while responses are taken; the rate is
//   set by the pipeline registers, with the multiplier of the span path and
//   the multiplier of each channel each in a stage of its own.
//   When the receiver holds rsp_ready low, the response stays on the outputs
//   and the stages behind it keep filling; req_ready drops only once all
//   four stages hold requests.
//   Reset clears the stage valid bits; no response is pending afterward.
module hsl_to_rgb_converter_top #(
  parameter int HUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [HUE_BITS-1:0] hue,
  input  logic [8:0]          saturation,
  input  logic [8:0]          lightness,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);
  import hslrgb_pkg::*;

  // One third of a turn, rounded to nearest.
  localparam longint unsigned TURN_L  = 64'd1 << HUE_BITS;
  localparam longint unsigned THIRD_L = (TURN_L + 64'd1) / 64'd3;
  localparam logic [HUE_BITS-1:0] THIRD_TURN = THIRD_L[HUE_BITS-1:0];
  localparam logic [HUE_BITS-1:0] NEG_THIRD  = HUE_BITS'(TURN_L - THIRD_L);

  hslrgb_adv_t adv;
  hslrgb_pq_t  pq2, pq3;

  hslrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .adv       (adv)
  );

  hslrgb_pq u_pq (
    .clk        (clk),
    .adv        (adv),
    .saturation (saturation),
    .lightness  (lightness),
    .pq2        (pq2),
    .pq3        (pq3)
  );

  hslrgb_chan #(.HUE_BITS(HUE_BITS), .HUE_OFFSET(THIRD_TURN)) u_red (
    .clk   (clk),
    .adv   (adv),
    .hue   (hue),
    .pq2   (pq2),
    .pq3   (pq3),
    .level (red)
  );

  hslrgb_chan #(.HUE_BITS(HUE_BITS), .HUE_OFFSET({HUE_BITS{1'b0}})) u_green (
    .clk   (clk),
    .adv   (adv),
    .hue   (hue),
    .pq2   (pq2),
    .pq3   (pq3),
    .level (green)
  );

  hslrgb_chan #(.HUE_BITS(HUE_BITS), .HUE_OFFSET(NEG_THIRD)) u_blue (
    .clk   (clk),
    .adv   (adv),
    .hue   (hue),
    .pq2   (pq2),
    .pq3   (pq3),
    .level (blue)
  );

endmodule

FILE: src/hslrgb_checker.sv
// Port-level checks for the HSL to RGB converter, bound to the top level.
// Depends only on the top level's ports.
module hslrgb_checker #(
  parameter int HUE_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [HUE_BITS-1:0] hue,
  input logic [8:0]          saturation,
  input logic [8:0]          lightness,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [7:0]          red,
  input logic [7:0]          green,
  input logic [7:0]          blue
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A gray or white request with a free-flowing output returns with all three
  // channels equal.
  a_gray_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (saturation == 9'd0 || lightness >= 9'd256))
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
    |=> rsp_valid && red == green && green == blue)
    else $error("gray request did not return equal channels on time");

  // Zero lightness is black whatever the hue.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && lightness == 9'd0)
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
    |=> rsp_valid && red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("black request did not return zero channels");

  // A waiting request holds its payload.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready
    |=> req_valid && $stable(hue) && $stable(saturation) && $stable(lightness))
    else $error("waiting request changed");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready
    |=> rsp_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled response changed");

endmodule

bind hsl_to_rgb_converter_top hslrgb_checker #(.HUE_BITS(HUE_BITS)) u_hslrgb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .hue        (hue),
  .saturation (saturation),
  .lightness  (lightness),
  .rsp_valid  (rsp_valid),
  .rsp_ready  (rsp_ready),
  .red        (red),
  .green      (green),
  .blue       (blue)
);
